[src/deq_pkg.sv]
// Shared action codes, status codes and controller command type for the deque.
package deq_pkg;

  localparam int WORD_W = 32;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH_HEAD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_TAIL = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_HEAD  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_TAIL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_OBSERVE   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
  } deq_cmd_t;

endpackage

[src/deq_ram.sv]
// Generic RAM with one write port and two registered read ports.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     rea_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic                     reb_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rea_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (reb_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[src/deq_ctrl.sv]
// Controller state machine sequencing one request through execute, fetch and report.
module deq_ctrl import deq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output deq_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       busy;
  logic       accept;

  assign busy   = (state_q == S_EXEC) || (state_q == S_FETCH);
  assign accept = start_i && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  state_d = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_d = S_FETCH;
      S_FETCH: state_d = S_DONE;
      S_DONE:  state_d = accept ? S_EXEC : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o      = busy;
  assign done_o      = (state_q == S_DONE);
  assign cmd_o.load  = accept;
  assign cmd_o.exec  = (state_q == S_EXEC);
  assign cmd_o.fetch = (state_q == S_FETCH);

endmodule

[src/deq_dp.sv]
// Datapath: ring pointers, count, ring store and result registers.
module deq_dp import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  deq_cmd_t                   cmd_i,
  input  logic [ACT_W-1:0]           action_i,
  input  logic signed [WORD_W-1:0]   value_i,
  output logic signed [WORD_W-1:0]   popped_value_o,
  output logic [STAT_W-1:0]          status_o,
  output logic signed [WORD_W-1:0]   front_value_o,
  output logic signed [WORD_W-1:0]   back_value_o,
  output logic [$clog2(DEPTH+1)-1:0] item_count_o,
  output logic                       is_empty_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] x);
    idx_up = (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] x);
    idx_down = (x == '0) ? LAST_IDX : x - 1'b1;
  endfunction

  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ACT_W-1:0]  action_q;
  logic [WORD_W-1:0] value_q;
  logic [WORD_W-1:0] popped_q, popped_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              pop_ok_q, pop_ok_d;

  logic              is_push;
  logic              is_pop;
  logic              full;
  logic              empty;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic              rea;
  logic              reb;
  logic [IDX_W-1:0]  raddr_a;
  logic [IDX_W-1:0]  raddr_b;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  assign is_push = (action_q == ACT_PUSH_HEAD) || (action_q == ACT_PUSH_TAIL);
  assign is_pop  = (action_q == ACT_POP_HEAD) || (action_q == ACT_POP_TAIL);
  assign full    = (count_q == FULL_CNT);
  assign empty   = (count_q == '0);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    popped_d = popped_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    we       = 1'b0;
    waddr    = tail_q;
    rea      = 1'b0;
    reb      = 1'b0;
    raddr_a  = head_q;
    raddr_b  = idx_down(tail_q);
    if (cmd_i.exec) begin
      status_d = ST_OK;
      popped_d = '0;
      pop_ok_d = 1'b0;
      if (is_push) begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
          if (action_q == ACT_PUSH_HEAD) begin
            head_d = idx_down(head_q);
            waddr  = idx_down(head_q);
          end else begin
            waddr  = tail_q;
            tail_d = idx_up(tail_q);
          end
        end
      end else if (is_pop) begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
          popped_d = EMPTY_WORD;
        end else begin
          rea      = 1'b1;
          pop_ok_d = 1'b1;
          count_d  = count_q - 1'b1;
          if (action_q == ACT_POP_HEAD) begin
            raddr_a = head_q;
            head_d  = idx_up(head_q);
          end else begin
            raddr_a = idx_down(tail_q);
            tail_d  = idx_down(tail_q);
          end
        end
      end
    end else if (cmd_i.fetch) begin
      rea = 1'b1;
      reb = 1'b1;
      if (pop_ok_q) begin
        popped_d = rdata_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      value_q  <= value_i;
    end
    popped_q <= popped_d;
    status_q <= status_d;
    pop_ok_q <= pop_ok_d;
  end

  deq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (value_q),
    .rea_i     (rea),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .reb_i     (reb),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign front_value_o  = empty ? EMPTY_WORD : rdata_a;
  assign back_value_o   = empty ? EMPTY_WORD : rdata_b;
  assign item_count_o   = count_q;
  assign is_empty_o     = empty;

endmodule

[src/double_ended_queue.sv]
// Top level of the bounded double-ended queue: controller, datapath and checks.
// The result strobe done_o rises once an accepted request has passed through the
// execute and fetch states; a new request may be accepted in the cycle done_o is
// high, but not while busy. The two ring-store read phases (pop word, then front
// and back words) of the registered-read RAM occupy the execute and fetch states.
// Reset clears pointers and count; store contents are undefined until written.
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ACT_W-1:0]           action_i,
  input  logic signed [WORD_W-1:0]   value_i,
  output logic                       done_o,
  output logic signed [WORD_W-1:0]   popped_value_o,
  output logic [STAT_W-1:0]          status_o,
  output logic signed [WORD_W-1:0]   front_value_o,
  output logic signed [WORD_W-1:0]   back_value_o,
  output logic [$clog2(DEPTH+1)-1:0] item_count_o,
  output logic                       is_empty_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  deq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .value_i        (value_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .item_count_o   (item_count_o),
    .is_empty_o     (is_empty_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result strobe missing three cycles after request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_count_o <= CNT_W'(DEPTH))
    else $error("item count exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_UNDERFLOW) |-> is_empty_o)
    else $error("underflow reported on non-empty queue");

endmodule
